@@ design/central_difference_gradient_top_macros.svh @@
// Assertion helpers shared by the gradient block.
// Every macro samples on the rising edge of clk and is quiet while arst_n is low.
`ifndef CENTRAL_DIFFERENCE_GRADIENT_TOP_MACROS_SVH
`define CENTRAL_DIFFERENCE_GRADIENT_TOP_MACROS_SVH

// The condition holds at every edge.
`define CDG_ASSERT_ALWAYS(label, cond) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error("gradient block check failed");

// When the antecedent holds, the consequent holds in the same cycle.
`define CDG_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("gradient block check failed");

// When the antecedent holds, the consequent holds in the following cycle.
`define CDG_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("gradient block check failed");

`endif

@@ design/cdg_pkg.sv @@
package cdg_pkg;

	localparam int DEFAULT_MAX_WIDTH = 2048;

	localparam int PIX_W  = 8;
	localparam int GRAD_W = 9;
	localparam int MAG_W  = 12;
	localparam int CFG_W  = 12;
	localparam int ROW_W  = 12;
	// Radicand is 64 * (gx^2 + gy^2), below 2^23; kept at an even width.
	localparam int SQ_W   = 2 * MAG_W;

	localparam logic [CFG_W-1:0] FRAME_WIDTH_RESET  = 12'd640;
	localparam logic [CFG_W-1:0] FRAME_HEIGHT_RESET = 12'd480;

	// Register indexes on the configuration port.
	localparam logic REG_FRAME_WIDTH  = 1'b0;
	localparam logic REG_FRAME_HEIGHT = 1'b1;

	// Item kinds.
	localparam logic OP_PIXEL = 1'b0;
	localparam logic OP_FLUSH = 1'b1;

	// Luma weights in 1/16384 units.
	localparam int GRAY_ACC_W = 22;
	localparam logic [GRAY_ACC_W-1:0] GRAY_COEF_B = 22'd1868;
	localparam logic [GRAY_ACC_W-1:0] GRAY_COEF_G = 22'd9617;
	localparam logic [GRAY_ACC_W-1:0] GRAY_COEF_R = 22'd4899;
	localparam logic [GRAY_ACC_W-1:0] GRAY_ROUND  = 22'd8192;

	function automatic logic [PIX_W-1:0] gray_of(
		input logic [PIX_W-1:0] b,
		input logic [PIX_W-1:0] g,
		input logic [PIX_W-1:0] r
	);
		logic [GRAY_ACC_W-1:0] acc;
		acc = GRAY_COEF_B * GRAY_ACC_W'(b) + GRAY_COEF_G * GRAY_ACC_W'(g)
			+ GRAY_COEF_R * GRAY_ACC_W'(r) + GRAY_ROUND;
		return acc[GRAY_ACC_W-1:GRAY_ACC_W-PIX_W];
	endfunction

endpackage

@@ design/central_difference_gradient_top.sv @@
// Channel   Direction  Handshake           Word
// input     in         in_valid/in_stall   op, blue, green, red
// output    out        out_valid/out_stall grad_x, grad_y, magnitude, last_of_frame
// config    in         cfg_write           cfg_index, cfg_data (no read-back)
//
// An item with a result goes from acceptance to the output register through two
// line store reads, the squaring, the root unit (12 bits, one per cycle, then a
// handover) and the load. A first-row pixel ends after CALC with no result, and
// a dropped item stays idle. Reset clears the frame position and neighbors;
// the line stores have no reset, and no result depends on an entry that was never written.
// A stalled output holds its word while the next item is taken and waits after its work.
module central_difference_gradient_top #(
	parameter int MAX_WIDTH = cdg_pkg::DEFAULT_MAX_WIDTH
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// configuration
	input  logic                                cfg_write,
	input  logic                                cfg_index,
	input  logic [cdg_pkg::CFG_W-1:0]           cfg_data,
	// pixel stream
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic                                op,
	input  logic [cdg_pkg::PIX_W-1:0]           blue,
	input  logic [cdg_pkg::PIX_W-1:0]           green,
	input  logic [cdg_pkg::PIX_W-1:0]           red,
	// gradient stream
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic signed [cdg_pkg::GRAD_W-1:0]   grad_x,
	output logic signed [cdg_pkg::GRAD_W-1:0]   grad_y,
	output logic [cdg_pkg::MAG_W-1:0]           magnitude,
	output logic                                last_of_frame
);

	`include "central_difference_gradient_top_macros.svh"

	// Column index width, and a compare width that holds both the register and
	// the line store depth.
	localparam int CW = $clog2(MAX_WIDTH);
	localparam int EW = (CW + 1 > cdg_pkg::CFG_W) ? CW + 1 : cdg_pkg::CFG_W;

	// Sequencer states. FETCH has the center and above pixels on the store
	// outputs, CALC has the right neighbor; the stores are written in CALC only,
	// so no read of an item can meet a write of the same item.
	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_FETCH = 3'd1;
	localparam logic [2:0] ST_CALC  = 3'd2;
	localparam logic [2:0] ST_SQ    = 3'd3;
	localparam logic [2:0] ST_ROOT  = 3'd4;
	localparam logic [2:0] ST_OUT   = 3'd5;

	logic [2:0] state_q;

	// Configuration and frame position.
	logic [cdg_pkg::CFG_W-1:0] frame_width_q;
	logic [cdg_pkg::CFG_W-1:0] frame_height_q;
	logic [CW-1:0]             column_q;
	logic [cdg_pkg::ROW_W-1:0] row_q;
	logic [cdg_pkg::PIX_W-1:0] left_q;
	logic [cdg_pkg::PIX_W-1:0] center_q;

	// Item being worked on.
	logic                      op_q;
	logic [cdg_pkg::PIX_W-1:0] blue_q;
	logic [cdg_pkg::PIX_W-1:0] green_q;
	logic [cdg_pkg::PIX_W-1:0] red_q;
	logic [cdg_pkg::PIX_W-1:0] gray_q;
	logic [cdg_pkg::PIX_W-1:0] above_q;
	logic signed [cdg_pkg::GRAD_W-1:0] gx_s2;
	logic signed [cdg_pkg::GRAD_W-1:0] gy_s2;
	logic                      last_s2;

	// Output register.
	logic                              out_valid_q;
	logic signed [cdg_pkg::GRAD_W-1:0] grad_x_q;
	logic signed [cdg_pkg::GRAD_W-1:0] grad_y_q;
	logic [cdg_pkg::MAG_W-1:0]         magnitude_q;
	logic                              last_q;

	// Effective width as the index of the last column: zero acts as one and
	// anything past the store depth is clipped to it.
	logic [EW-1:0] fw_ext;
	logic [CW-1:0] col_max;
	logic [cdg_pkg::ROW_W-1:0] h_eff;
	logic          complete;
	logic          col_last;
	logic [CW-1:0] next_col;

	assign fw_ext = EW'(frame_width_q);

	always_comb begin
		if (frame_width_q == '0) begin
			col_max = '0;
		end else if (fw_ext > EW'(MAX_WIDTH)) begin
			col_max = CW'(MAX_WIDTH - 1);
		end else begin
			col_max = CW'(fw_ext - EW'(1));
		end
	end

	assign h_eff    = (frame_height_q == '0) ? cdg_pkg::ROW_W'(1) : frame_height_q;
	assign complete = row_q >= h_eff;
	assign col_last = column_q == col_max;
	assign next_col = col_last ? '0 : column_q + 1'b1;

	// Input handshake. A flush only counts once every row is in, a pixel only
	// before that; the other kind is taken and dropped.
	logic in_acc;
	logic proceed;

	assign in_stall = state_q != ST_IDLE;
	assign in_acc   = in_valid && !in_stall;
	assign proceed  = in_acc && ((op == cdg_pkg::OP_FLUSH) == complete);

	// Line stores: the upper one holds row r-2, the middle one row r-1.
	logic                      line_we;
	logic [CW-1:0]             mid_raddr;
	logic [cdg_pkg::PIX_W-1:0] mid_rdata;
	logic [cdg_pkg::PIX_W-1:0] up_rdata;

	assign line_we   = (state_q == ST_CALC) && (op_q == cdg_pkg::OP_PIXEL);
	assign mid_raddr = (state_q == ST_FETCH) ? next_col : column_q;

	cdg_ram #(
		.WIDTH(cdg_pkg::PIX_W),
		.DEPTH(MAX_WIDTH)
	) u_upper_line (
		.clk  (clk),
		.we   (line_we),
		.waddr(column_q),
		.wdata(center_q),
		.raddr(column_q),
		.rdata(up_rdata)
	);

	cdg_ram #(
		.WIDTH(cdg_pkg::PIX_W),
		.DEPTH(MAX_WIDTH)
	) u_middle_line (
		.clk  (clk),
		.we   (line_we),
		.waddr(column_q),
		.wdata(gray_q),
		.raddr(mid_raddr),
		.rdata(mid_rdata)
	);

	// Central differences. Border columns give no horizontal gradient; the
	// second row, which has no row above its center, gives no vertical one.
	logic [cdg_pkg::PIX_W-1:0]  right_pix;
	logic signed [cdg_pkg::GRAD_W-1:0] gx_calc;
	logic signed [cdg_pkg::GRAD_W-1:0] gy_calc;
	logic                       has_result;

	assign right_pix = col_last ? '0 : mid_rdata;

	always_comb begin
		if (column_q == '0 || col_last) begin
			gx_calc = '0;
		end else begin
			gx_calc = $signed({1'b0, right_pix} - {1'b0, left_q});
		end
		if (op_q == cdg_pkg::OP_FLUSH || row_q == cdg_pkg::ROW_W'(1)) begin
			gy_calc = '0;
		end else begin
			gy_calc = $signed({1'b0, gray_q} - {1'b0, above_q});
		end
	end

	assign has_result = (op_q == cdg_pkg::OP_FLUSH) || (row_q != '0);

	// Radicand 64 * (gx^2 + gy^2) for the root unit.
	logic signed [2*cdg_pkg::GRAD_W-1:0] gx_sq;
	logic signed [2*cdg_pkg::GRAD_W-1:0] gy_sq;
	logic [2*cdg_pkg::GRAD_W-1:0]        sq_sum;
	logic [cdg_pkg::SQ_W-1:0]            radicand;
	logic                                root_start;
	logic                                root_done;
	logic [cdg_pkg::MAG_W-1:0]           root;

	assign gx_sq      = gx_s2 * gx_s2;
	assign gy_sq      = gy_s2 * gy_s2;
	assign sq_sum     = $unsigned(gx_sq) + $unsigned(gy_sq);
	assign radicand   = cdg_pkg::SQ_W'({sq_sum, 6'b000000});
	assign root_start = state_q == ST_SQ;

	cdg_isqrt u_isqrt (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (root_start),
		.radicand(radicand),
		.done    (root_done),
		.root    (root)
	);

	logic load_out;
	assign load_out = (state_q == ST_OUT) && (!out_valid_q || !out_stall);

	// Sequencer, frame position and configuration.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			frame_width_q  <= cdg_pkg::FRAME_WIDTH_RESET;
			frame_height_q <= cdg_pkg::FRAME_HEIGHT_RESET;
			column_q       <= '0;
			row_q          <= '0;
			left_q         <= '0;
			center_q       <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (proceed) begin
						state_q <= ST_FETCH;
					end
				end
				ST_FETCH: begin
					center_q <= mid_rdata;
					state_q  <= ST_CALC;
				end
				ST_CALC: begin
					left_q <= center_q;
					if (col_last) begin
						column_q <= '0;
						if (op_q == cdg_pkg::OP_FLUSH) begin
							row_q <= '0;
						end else begin
							row_q <= row_q + 1'b1;
						end
					end else begin
						column_q <= column_q + 1'b1;
					end
					state_q <= has_result ? ST_SQ : ST_IDLE;
				end
				ST_SQ: begin
					state_q <= ST_ROOT;
				end
				ST_ROOT: begin
					if (root_done) begin
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (load_out) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase

			// A register write restarts the frame position.
			if (cfg_write) begin
				if (cfg_index == cdg_pkg::REG_FRAME_WIDTH) begin
					frame_width_q <= cfg_data;
				end else begin
					frame_height_q <= cfg_data;
				end
				column_q <= '0;
				row_q    <= '0;
			end
		end
	end

	// Item payload.
	always_ff @(posedge clk) begin
		if (in_acc) begin
			op_q    <= op;
			blue_q  <= blue;
			green_q <= green;
			red_q   <= red;
		end
		if (state_q == ST_FETCH) begin
			above_q <= up_rdata;
			gray_q  <= cdg_pkg::gray_of(blue_q, green_q, red_q);
		end
		if (state_q == ST_CALC) begin
			gx_s2   <= gx_calc;
			gy_s2   <= gy_calc;
			last_s2 <= (op_q == cdg_pkg::OP_FLUSH) && col_last;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			grad_x_q    <= gx_s2;
			grad_y_q    <= gy_s2;
			magnitude_q <= root;
			last_q      <= last_s2;
		end
	end

	assign out_valid     = out_valid_q;
	assign grad_x        = grad_x_q;
	assign grad_y        = grad_y_q;
	assign magnitude     = magnitude_q;
	assign last_of_frame = last_q;

	// The frame position never runs past the configured frame.
	`CDG_ASSERT_ALWAYS(a_column_in_frame, column_q <= col_max)
	`CDG_ASSERT_ALWAYS(a_row_in_frame, row_q <= h_eff)
	// The root unit only finishes while the sequencer waits for it.
	`CDG_ASSERT_NOW(a_root_done_in_wait, root_done, state_q == ST_ROOT)
	// The frame's final result lies on the bottom row, which has no row below.
	`CDG_ASSERT_NOW(a_last_flat_y, out_valid_q && last_q, grad_y_q == '0)
	// A dropped item leaves no work behind.
	`CDG_ASSERT_NEXT(a_drop_idle, in_acc && !proceed, state_q == ST_IDLE)

endmodule

@@ design/cdg_ram.sv @@
module cdg_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2048
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

@@ design/cdg_isqrt.sv @@
// Floor square root, two radicand bits per cycle, one root bit per cycle.
module cdg_isqrt (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [cdg_pkg::SQ_W-1:0]   radicand,
	output logic                       done,
	output logic [cdg_pkg::MAG_W-1:0]  root
);

	localparam int RW   = cdg_pkg::MAG_W + 1;
	localparam int CNTW = $clog2(cdg_pkg::MAG_W + 1);

	logic [cdg_pkg::SQ_W-1:0]  rad_q;
	logic [RW-1:0]             rem_q;
	logic [cdg_pkg::MAG_W-1:0] root_q;
	logic [CNTW-1:0]           cnt_q;
	logic                      done_q;

	logic [RW+1:0] rem_sh;
	logic [RW+1:0] trial;
	logic          fits;

	assign rem_sh = {rem_q, rad_q[cdg_pkg::SQ_W-1 -: 2]};
	assign trial  = {1'b0, root_q, 2'b01};
	assign fits   = rem_sh >= trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q <= CNTW'(cdg_pkg::MAG_W);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - 1'b1;
				done_q <= (cnt_q == CNTW'(1));
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rad_q  <= radicand;
			rem_q  <= '0;
			root_q <= '0;
		end else if (cnt_q != '0) begin
			rad_q <= {rad_q[cdg_pkg::SQ_W-3:0], 2'b00};
			if (fits) begin
				rem_q  <= RW'(rem_sh - trial);
				root_q <= {root_q[cdg_pkg::MAG_W-2:0], 1'b1};
			end else begin
				rem_q  <= rem_sh[RW-1:0];
				root_q <= {root_q[cdg_pkg::MAG_W-2:0], 1'b0};
			end
		end
	end

	assign done = done_q;
	assign root = root_q;

endmodule
